// ----- rtl/core/ble_adv_local_name_extractor_core_defines.svh -----
// assertion macros for the local name extractor rtl
// no dependencies; included by the emitter, which checks its own logic
`ifndef BLE_ADV_LOCAL_NAME_EXTRACTOR_CORE_DEFINES_SVH
`define BLE_ADV_LOCAL_NAME_EXTRACTOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define BLN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled while in reset
`define BLN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BLN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BLN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/blane_pkg.sv -----
// types and constants for the local name extractor
// used by the parser, emitter and top level
package blane_pkg;

    localparam int NAME_MAX_DEF = 31;

    localparam logic [7:0] AD_TYPE_SHORT_NAME    = 8'd8;
    localparam logic [7:0] AD_TYPE_COMPLETE_NAME = 8'd9;

    typedef struct packed {
        logic [7:0] ad_byte;
        logic       has_byte;
        logic       last_byte;
    } t_bln_in;

    typedef struct packed {
        logic       name_found;
        logic [7:0] name_byte;
        logic       byte_valid;
        logic [4:0] name_length;
        logic       last_result;
    } t_bln_out;

    // handed from parser to emitter at the end of a payload
    typedef struct packed {
        logic       found;
        logic [4:0] len;
        logic       bank;
    } t_bln_emit_req;

endpackage

// ----- rtl/core/blane_name_mem.sv -----
// two-bank name byte store, one write and one registered read port
// depends on nothing but its parameter
module blane_name_mem #(
    parameter int NAME_MAX = 31
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [$clog2(2*NAME_MAX)-1:0]   i_wr_addr,
    input  logic [7:0]                      i_wr_data,
    input  logic                            i_rd_en,
    input  logic [$clog2(2*NAME_MAX)-1:0]   i_rd_addr,
    output logic [7:0]                      o_rd_data
);
    localparam int DEPTH = 2 * NAME_MAX;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/blane_parser.sv -----
// length-type-value walker: writes candidate names to the inactive bank
// depends on blane_pkg
module blane_parser #(
    parameter int NAME_MAX = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  blane_pkg::t_bln_in              i_item,
    input  logic [4:0]                      i_max_name_len,
    output logic                            o_start,
    output blane_pkg::t_bln_emit_req        o_req,
    output logic                            o_wr_en,
    output logic [$clog2(2*NAME_MAX)-1:0]   o_wr_addr,
    output logic [7:0]                      o_wr_data
);
    import blane_pkg::*;

    localparam int AW = $clog2(2*NAME_MAX);
    localparam logic [6:0] NM7 = 7'(NAME_MAX);

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_TYPE  = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_remaining, n_remaining;
    logic       r_segment, n_segment;
    logic [4:0] r_cand_len, n_cand_len;
    logic       r_bank, n_bank;
    logic [4:0] r_commit_len, n_commit_len;
    logic       r_found, n_found;

    logic [4:0] limit;
    logic       seg_new;
    logic [7:0] rem_dec;
    logic [6:0] wr_idx;

    assign limit   = ({2'b00, i_max_name_len} < NM7) ? i_max_name_len : NM7[4:0];
    assign rem_dec = r_remaining - 8'd1;
    assign seg_new = ((i_item.ad_byte == AD_TYPE_SHORT_NAME) ||
                      (i_item.ad_byte == AD_TYPE_COMPLETE_NAME)) && (r_remaining > 8'd1);
    // candidate goes into the bank that is not active
    assign wr_idx  = r_bank ? {2'b00, r_cand_len} : (NM7 + {2'b00, r_cand_len});

    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_segment    = r_segment;
        n_cand_len   = r_cand_len;
        n_bank       = r_bank;
        n_commit_len = r_commit_len;
        n_found      = r_found;
        o_wr_en      = 1'b0;
        o_wr_addr    = wr_idx[AW-1:0];
        o_wr_data    = i_item.ad_byte;

        if (i_accept && i_item.has_byte) begin
            case (r_phase)
                PH_TYPE: begin
                    n_cand_len  = 5'd0;
                    n_remaining = rem_dec;
                    if (rem_dec == 8'd0) begin
                        if (seg_new) begin
                            n_bank       = ~r_bank;
                            n_commit_len = 5'd0;
                            n_found      = 1'b1;
                        end
                        n_segment = 1'b0;
                        n_phase   = PH_LEN;
                    end else begin
                        n_segment = seg_new;
                        n_phase   = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (r_segment && (r_cand_len < limit)) begin
                        o_wr_en    = 1'b1;
                        n_cand_len = r_cand_len + 5'd1;
                    end
                    n_remaining = rem_dec;
                    if (rem_dec == 8'd0) begin
                        if (r_segment) begin
                            n_bank       = ~r_bank;
                            n_commit_len = n_cand_len;
                            n_found      = 1'b1;
                        end
                        n_segment = 1'b0;
                        n_phase   = PH_LEN;
                    end
                end
                default: begin
                    // zero length byte is padding
                    n_phase = PH_LEN;
                    if (i_item.ad_byte != 8'd0) begin
                        n_remaining = i_item.ad_byte;
                        n_phase     = PH_TYPE;
                    end
                end
            endcase
        end

        o_start     = i_accept && i_item.last_byte;
        o_req.found = n_found;
        o_req.len   = n_commit_len;
        o_req.bank  = n_bank;

        // open structure is dropped at payload end
        if (o_start) begin
            n_phase      = PH_LEN;
            n_remaining  = 8'd0;
            n_segment    = 1'b0;
            n_cand_len   = 5'd0;
            n_commit_len = 5'd0;
            n_found      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_remaining  <= 8'd0;
            r_segment    <= 1'b0;
            r_cand_len   <= 5'd0;
            r_bank       <= 1'b0;
            r_commit_len <= 5'd0;
            r_found      <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_segment    <= n_segment;
            r_cand_len   <= n_cand_len;
            r_bank       <= n_bank;
            r_commit_len <= n_commit_len;
            r_found      <= n_found;
        end
    end

endmodule

// ----- rtl/core/blane_emitter.sv -----
// result sequencer: reads the committed name one byte at a time
// depends on blane_pkg and the assertion macro header
`include "ble_adv_local_name_extractor_core_defines.svh"

module blane_emitter #(
    parameter int NAME_MAX = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  blane_pkg::t_bln_emit_req        i_req,
    output logic                            o_busy,
    output logic                            o_rd_en,
    output logic [$clog2(2*NAME_MAX)-1:0]   o_rd_addr,
    input  logic [7:0]                      i_rd_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output blane_pkg::t_bln_out             o_out_data
);
    import blane_pkg::*;

    localparam int AW = $clog2(2*NAME_MAX);
    localparam logic [6:0] NM7 = 7'(NAME_MAX);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_LOAD = 2'd2,
        S_HOLD = 2'd3
    } t_state;

    t_state        r_state;
    t_bln_emit_req r_req;
    logic [4:0]    r_idx;
    logic          r_out_valid;
    t_bln_out      r_out;
    logic [6:0]    rd_idx;
    logic [4:0]    idx_inc;

    assign idx_inc   = r_idx + 5'd1;
    assign rd_idx    = r_req.bank ? (NM7 + {2'b00, r_idx}) : {2'b00, r_idx};
    assign o_rd_addr = rd_idx[AW-1:0];
    assign o_rd_en   = (r_state == S_RD);
    assign o_busy    = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= 5'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req <= i_req;
                        r_idx <= 5'd0;
                        if (!i_req.found || (i_req.len == 5'd0)) begin
                            r_out.name_found  <= i_req.found;
                            r_out.name_byte   <= 8'd0;
                            r_out.byte_valid  <= 1'b0;
                            r_out.name_length <= 5'd0;
                            r_out.last_result <= 1'b1;
                            r_out_valid       <= 1'b1;
                            r_state           <= S_HOLD;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out.name_found  <= 1'b1;
                    r_out.name_byte   <= i_rd_data;
                    r_out.byte_valid  <= 1'b1;
                    r_out.name_length <= r_req.len;
                    r_out.last_result <= (idx_inc == r_req.len);
                    r_out_valid       <= 1'b1;
                    r_state           <= S_HOLD;
                end
                S_HOLD: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last_result) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BLN_ASSERT_IMPL(a_start_when_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE)
    `BLN_ASSERT_IMPL(a_byte_needs_name, i_clk, i_rst_n, r_out_valid && r_out.byte_valid, r_req.found)
    `BLN_ASSERT_NEXT(a_next_byte_fetch, i_clk, i_rst_n, r_out_valid && !i_out_stall && !r_out.last_result, r_state == S_RD)
    `BLN_ASSERT_IMPL(a_valid_in_hold, i_clk, i_rst_n, r_out_valid, r_state == S_HOLD)

endmodule

// ----- rtl/core/ble_adv_local_name_extractor_core.sv -----
// local name extractor top: parser, two-bank name store, result emitter
// non-final payload items are taken one per cycle when not stalled; the final item
// starts emission; empty result: valid in the cycle after the final item; name:
// each byte goes through store read, load and handshake, which waits out output stall
// input is stalled from the final item until the last result is taken
// synchronous active-low reset clears control state; the name store is not cleared
module ble_adv_local_name_extractor_core #(
    parameter int NAME_MAX = blane_pkg::NAME_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  blane_pkg::t_bln_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output blane_pkg::t_bln_out  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [4:0]           i_cfg_data
);
    import blane_pkg::*;

    localparam int AW = $clog2(2*NAME_MAX);

    logic          r_max_name_len;
    logic [4:0]    r_max_len;
    logic          accept;
    logic          busy;
    logic          start;
    t_bln_emit_req req;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;

    // marks that the register has been written since reset and stores the written limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name_len <= 1'b0;
            r_max_len      <= 5'd31;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_name_len <= 1'b1;
            r_max_len      <= i_cfg_data;
        end
    end

    blane_parser #(
        .NAME_MAX (NAME_MAX)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_in_data),
        .i_max_name_len (r_max_name_len ? r_max_len : 5'd31),
        .o_start        (start),
        .o_req          (req),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    blane_name_mem #(
        .NAME_MAX (NAME_MAX)
    ) u_name_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    blane_emitter #(
        .NAME_MAX (NAME_MAX)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_busy      (busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
